// ===== rtl/bspl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_pkg
// Shared types and constants for the partition tree point locator.
// ----------------------------------------------------------------------------
package bspl_pkg;

   localparam int COORD_W  = 16;
   localparam int LINK_W   = 16;
   localparam int SUB_W    = 15;
   localparam int INDEX_W  = 13;
   localparam int COUNT_W  = 14;
   localparam int CSR_W    = 32;
   localparam int PADDR_W  = 2;
   localparam int ENTRY_W  = 4 * COORD_W + 2 * LINK_W;

   // child link: top bit flags a leaf, low bits name the subsector
   localparam int LEAF_BIT = 15;
   localparam logic [LINK_W-1:0] LEAF_FLAG = 16'h8000;
   localparam logic [LINK_W-1:0] LEAF_MASK = 16'h7FFF;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOCATE = 1'b1;

   localparam int REG_NODE_COUNT = 0;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_FETCH  = 5'b00010,
      ST_MULT   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic wr_node;   // store the accepted node
      logic start;     // latch point and count, reset walk
      logic rd_en;     // read node at current index
      logic mul_en;    // form the two side products
      logic step_en;   // pick child, update index and result
      logic load_out;  // move result into the output register
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic leaf;
      logic bad;
   } status_type;

endpackage

// ===== rtl/bspl_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_req_if
// Request channel: node writes and point locates.
// ----------------------------------------------------------------------------
interface bspl_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [12:0] node_index;
   logic signed [15:0] line_x;
   logic signed [15:0] line_y;
   logic signed [15:0] line_dx;
   logic signed [15:0] line_dy;
   logic [15:0] child_front;
   logic [15:0] child_back;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;

   modport source (
      output valid, opcode, node_index, line_x, line_y, line_dx, line_dy,
             child_front, child_back, point_x, point_y,
      input  ready
   );
   modport sink (
      input  valid, opcode, node_index, line_x, line_y, line_dx, line_dy,
             child_front, child_back, point_x, point_y,
      output ready
   );
endinterface

// ===== rtl/bspl_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_rsp_if
// Response channel: located subsector and walk error flag.
// ----------------------------------------------------------------------------
interface bspl_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] subsector_index;
   logic        walk_error;

   modport source (
      output valid, subsector_index, walk_error,
      input  ready
   );
   modport sink (
      input  valid, subsector_index, walk_error,
      output ready
   );
endinterface

// ===== rtl/bsp_point_locate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_point_locate
// Point location in a binary space partition tree held in on-chip memory.
//
// req_ch takes items: opcode write stores one node (line x, y, dx, dy and two
// child links) at node_index; opcode locate walks from the root, node
// node_count-1, and returns one item on rsp_ch with the leaf subsector and an
// error flag for a bad child link or an overlong walk. Writes return nothing.
// node_count is set through the APB-style port at address 0; the user must
// set it only while idle, which the block itself does not enforce. A write is
// stored when accepted. A locate is accepted, then each tree level visited
// takes a memory read, two 17x16 products, and a sum with child select, and
// the result then moves into the output register; the single memory read port
// and the per-level multiply set this pace. An empty table skips the walk.
// The output register holds one result; while it waits the block still takes
// writes and starts the next locate, which then waits in its last step until
// the receiver takes the held result. Reset clears node_count and all control
// state; node memory contents stay undefined until written.
// ----------------------------------------------------------------------------
module bsp_point_locate #(
   parameter int NODE_DEPTH = 8192
) (
   input  logic                          clock,
   input  logic                          reset,
   bspl_req_if.sink                      req_ch,
   bspl_rsp_if.source                    rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bspl_pkg::PADDR_W-1:0]  paddr,
   input  logic [bspl_pkg::CSR_W-1:0]    pwdata,
   output logic [bspl_pkg::CSR_W-1:0]    prdata,
   output logic                          pready
);

   logic [bspl_pkg::COUNT_W-1:0] node_count_ff;
   logic                         csr_hit;
   logic                         csr_write;

   bspl_pkg::cmd_type    cmd;
   bspl_pkg::status_type status;

   assign pready    = 1'b1;
   assign csr_hit   = (32'(paddr >> 2) == bspl_pkg::REG_NODE_COUNT);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign prdata    = csr_hit ? bspl_pkg::CSR_W'(node_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else if (csr_write) begin
         node_count_ff <= pwdata[bspl_pkg::COUNT_W-1:0];
      end
   end

   bspl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .status     (status),
      .cmd        (cmd)
   );

   bspl_datapath #(
      .NODE_DEPTH (NODE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cfg_count       (node_count_ff),
      .node_index      (req_ch.node_index),
      .line_x          (req_ch.line_x),
      .line_y          (req_ch.line_y),
      .line_dx         (req_ch.line_dx),
      .line_dy         (req_ch.line_dy),
      .child_front     (req_ch.child_front),
      .child_back      (req_ch.child_back),
      .point_x         (req_ch.point_x),
      .point_y         (req_ch.point_y),
      .subsector_index (rsp_ch.subsector_index),
      .walk_error      (rsp_ch.walk_error)
   );

endmodule

// ===== rtl/bspl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_ctrl
// Walk sequencer: fetch, multiply, decide per tree level; output handshake.
// ----------------------------------------------------------------------------
module bspl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_opcode,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bspl_pkg::status_type  status,
   output bspl_pkg::cmd_type     cmd
);

   bspl_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept;
   logic out_free;

   assign req_ready  = (state_ff == bspl_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         bspl_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_opcode == bspl_pkg::OP_WRITE) begin
                  cmd.wr_node = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = status.count_zero ? bspl_pkg::ST_FINISH : bspl_pkg::ST_FETCH;
               end
            end
         end
         bspl_pkg::ST_FETCH: begin
            cmd.rd_en = 1'b1;
            state_in  = bspl_pkg::ST_MULT;
         end
         bspl_pkg::ST_MULT: begin
            cmd.mul_en = 1'b1;
            state_in   = bspl_pkg::ST_DECIDE;
         end
         bspl_pkg::ST_DECIDE: begin
            cmd.step_en = 1'b1;
            state_in    = (status.leaf || status.bad) ? bspl_pkg::ST_FINISH
                                                      : bspl_pkg::ST_FETCH;
         end
         bspl_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bspl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bspl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bspl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a held result must never be overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");

   a_start_walk: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && !status.count_zero) |=> (state_ff == bspl_pkg::ST_FETCH))
      else $error("locate did not start a walk");

   a_continue_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bspl_pkg::ST_DECIDE && !status.leaf && !status.bad)
      |=> (state_ff == bspl_pkg::ST_FETCH))
      else $error("inner node did not lead to a fetch");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bspl_pkg::ST_FINISH))
      else $error("result raised outside finish");

endmodule

// ===== rtl/bspl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_datapath
// Node memory, side test arithmetic, walk index and result registers.
// ----------------------------------------------------------------------------
module bspl_datapath #(
   parameter int NODE_DEPTH = 8192
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bspl_pkg::cmd_type                    cmd,
   output bspl_pkg::status_type                 status,
   input  logic [bspl_pkg::COUNT_W-1:0]         cfg_count,
   input  logic [bspl_pkg::INDEX_W-1:0]         node_index,
   input  logic signed [bspl_pkg::COORD_W-1:0]  line_x,
   input  logic signed [bspl_pkg::COORD_W-1:0]  line_y,
   input  logic signed [bspl_pkg::COORD_W-1:0]  line_dx,
   input  logic signed [bspl_pkg::COORD_W-1:0]  line_dy,
   input  logic [bspl_pkg::LINK_W-1:0]          child_front,
   input  logic [bspl_pkg::LINK_W-1:0]          child_back,
   input  logic signed [bspl_pkg::COORD_W-1:0]  point_x,
   input  logic signed [bspl_pkg::COORD_W-1:0]  point_y,
   output logic [bspl_pkg::SUB_W-1:0]           subsector_index,
   output logic                                 walk_error
);

   localparam int AW = $clog2(NODE_DEPTH);
   localparam int CW = $clog2(NODE_DEPTH + 1);
   localparam int CX = bspl_pkg::COORD_W;

   logic [bspl_pkg::ENTRY_W-1:0] mem [NODE_DEPTH];
   logic [bspl_pkg::ENTRY_W-1:0] rd_data_ff;

   logic [AW-1:0] wr_addr;
   logic          wr_in_range;
   logic [CW-1:0] live_count;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] visits_ff;
   logic [AW-1:0] cur_ff;
   logic signed [CX-1:0] px_ff, py_ff;

   logic signed [CX-1:0] nx, ny, dx, dy;
   logic [bspl_pkg::LINK_W-1:0] link_front, link_back;
   logic signed [CX:0]   diff_y, diff_x;
   logic signed [2*CX:0] prod_a_ff, prod_b_ff;
   logic signed [2*CX+1:0] side;
   logic                 side_pos;
   logic [bspl_pkg::LINK_W-1:0] link_sel;

   logic [bspl_pkg::SUB_W-1:0] res_sub_ff;
   logic                       res_err_ff;
   logic [bspl_pkg::SUB_W-1:0] out_sub_ff;
   logic                       out_err_ff;

   assign wr_addr     = AW'(node_index);
   assign wr_in_range = (32'(node_index) < NODE_DEPTH);
   // count beyond the table is clipped to the table
   assign live_count  = (32'(cfg_count) > NODE_DEPTH) ? CW'(NODE_DEPTH) : CW'(cfg_count);

   assign nx         = rd_data_ff[CX-1:0];
   assign ny         = rd_data_ff[2*CX-1:CX];
   assign dx         = rd_data_ff[3*CX-1:2*CX];
   assign dy         = rd_data_ff[4*CX-1:3*CX];
   assign link_front = rd_data_ff[4*CX+bspl_pkg::LINK_W-1:4*CX];
   assign link_back  = rd_data_ff[4*CX+2*bspl_pkg::LINK_W-1:4*CX+bspl_pkg::LINK_W];

   assign diff_y = {py_ff[CX-1], py_ff} - {ny[CX-1], ny};
   assign diff_x = {nx[CX-1], nx} - {px_ff[CX-1], px_ff};

   assign side     = {prod_a_ff[2*CX], prod_a_ff} + {prod_b_ff[2*CX], prod_b_ff};
   assign side_pos = !side[2*CX+1] && (side != '0);
   assign link_sel = side_pos ? link_back : link_front;

   assign status.count_zero = (cfg_count == '0);
   assign status.leaf       = link_sel[bspl_pkg::LEAF_BIT];
   assign status.bad        = !link_sel[bspl_pkg::LEAF_BIT]
                              && ((link_sel >= 16'(count_ff)) || (visits_ff >= count_ff));

   always_ff @(posedge clock) begin
      if (cmd.wr_node && wr_in_range) begin
         mem[wr_addr] <= {child_back, child_front, line_dy, line_dx, line_y, line_x};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff    <= point_x;
         py_ff    <= point_y;
         count_ff <= live_count;
         cur_ff   <= AW'(live_count - 1'b1);
      end else if (cmd.step_en) begin
         cur_ff   <= link_sel[AW-1:0];
      end
      if (cmd.mul_en) begin
         prod_a_ff <= diff_y * dx;
         prod_b_ff <= diff_x * dy;
      end
      if (cmd.load_out) begin
         out_sub_ff <= res_sub_ff;
         out_err_ff <= res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visits_ff  <= '0;
         res_sub_ff <= '0;
         res_err_ff <= 1'b0;
      end else if (cmd.start) begin
         visits_ff  <= '0;
         res_sub_ff <= '0;
         res_err_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            visits_ff <= visits_ff + 1'b1;
         end
         if (cmd.step_en) begin
            if (status.leaf) begin
               res_sub_ff <= link_sel[bspl_pkg::SUB_W-1:0] & bspl_pkg::LEAF_MASK[bspl_pkg::SUB_W-1:0];
            end else if (status.bad) begin
               res_err_ff <= 1'b1;
            end
         end
      end
   end

   assign subsector_index = out_sub_ff;
   assign walk_error      = out_err_ff;

endmodule
